// ===== rtl/decparse_pkg.sv =====
// shared types and constants for the decimal entry parser
package decparse_pkg;

    // entry stack depth and derived widths
    localparam int STACK_DEPTH  = 32;
    localparam int ADDR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);

    // transaction field widths
    localparam int CHAR_W       = 8;
    localparam int NUM_W        = 64;
    localparam int CHAR_COUNT_W = 6;
    localparam int STATUS_W     = 2;
    localparam int DIGIT_W      = 4;

    // div10 sequencer: fold steps of the reciprocal series
    localparam int FOLD_STEPS   = 4;
    localparam int FOLD_W       = $clog2(FOLD_STEPS);

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC  = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // class of a kept character
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_MINUS = 2'd1,
        KIND_PLUS  = 2'd2
    } t_kind;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY_BS     = 2'd1,
        ST_OVERFLOW     = 2'd2
    } t_status;

    // work handed from the stack stage to the accumulator stage
    typedef enum logic [2:0] {
        OP_DIGIT = 3'd0,
        OP_MINUS = 3'd1,
        OP_PLUS  = 3'd2,
        OP_POP   = 3'd3,
        OP_TERM  = 3'd4,
        OP_ERR   = 3'd5
    } t_op;

    // div10 unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/decimal_entry_parser_with_backspace.sv =====
// top level: decimal entry parser with backspace, stack memory and accumulator stage
// a terminating or error transaction passes through the stage 1 register and then the output register
// throughput: one character per cycle while stage 1 is not stalled; a backspace that removes a digit
//   holds the input while the div10 sequencer runs, and an ending or error waits for the output register
// reset: synchronous active-low reset clears the count, accumulator, sign and handshake
//   state; the class stack memory is not cleared and is only read below the count
module decimal_entry_parser_with_backspace (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [decparse_pkg::CHAR_W-1:0]         i_char_code,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [decparse_pkg::NUM_W-1:0]   o_number,
    output logic [decparse_pkg::CHAR_COUNT_W-1:0]   o_char_count,
    output logic [decparse_pkg::STATUS_W-1:0]       o_status
);
    import decparse_pkg::*;

    // ------------------------------------------------------------------
    // stage 0: classify, keep count, push/pop the class stack
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   r_count, n_count;
    t_kind              r_stack [STACK_DEPTH];
    t_kind              r_kind;         // registered stack read data

    logic               w_accept;
    logic               w_is_term;
    logic               w_is_digit;
    logic               w_is_sign;
    logic               w_front_valid;
    t_op                w_front_op;
    t_status            w_front_status;
    logic               w_push;
    t_kind              w_push_kind;
    logic               w_pop;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [CNT_W-1:0]   w_count_dec;

    // ------------------------------------------------------------------
    // stage 1: accumulator and sign, result generation
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    t_op                r_s1_op;
    t_status            r_s1_status;
    logic [DIGIT_W-1:0] r_s1_digit;
    logic [CNT_W-1:0]   r_s1_count;

    logic [NUM_W-1:0]   r_acc;
    logic               r_neg;

    logic               w_s1_retire;
    logic               w_emit;
    logic               w_out_free;
    logic               w_div_start;
    t_div_status        w_div;
    logic [NUM_W-1:0]   w_div_quot;
    logic [NUM_W-1:0]   w_acc_x10;
    logic [CNT_W:0]     w_count_sum;

    // output register
    logic                       r_out_valid;
    logic signed [NUM_W-1:0]    r_out_number;
    logic [CHAR_COUNT_W-1:0]    r_out_count;
    t_status                    r_out_status;

    // ------------------------------------------------------------------
    // handshake: stage 0 advances whenever stage 1 is empty or retiring
    // ------------------------------------------------------------------
    assign o_in_stall = r_s1_valid && !w_s1_retire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // character classes
    assign w_is_term  = (i_char_code == CH_LF)  || (i_char_code == CH_CR) ||
                        (i_char_code == CH_ESC) || (i_char_code == CH_NUL);
    assign w_is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign w_is_sign  = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS);

    assign w_count_dec = r_count - 1'b1;
    assign w_wr_addr   = r_count[ADDR_W-1:0];
    assign w_rd_addr   = w_count_dec[ADDR_W-1:0];

    always_comb begin
        w_front_valid  = 1'b0;
        w_front_op     = OP_DIGIT;
        w_front_status = ST_OK;
        w_push         = 1'b0;
        w_push_kind    = KIND_DIGIT;
        w_pop          = 1'b0;
        n_count        = r_count;
        if (w_is_term) begin
            // entry ends: count snapshot travels with the op
            w_front_valid = 1'b1;
            w_front_op    = OP_TERM;
            n_count       = '0;
        end else if (w_is_sign && (r_count == '0)) begin
            // sign only as first kept char; never overflows at count zero
            w_front_valid = 1'b1;
            w_front_op    = (i_char_code == CH_MINUS) ? OP_MINUS : OP_PLUS;
            w_push        = 1'b1;
            w_push_kind   = (i_char_code == CH_MINUS) ? KIND_MINUS : KIND_PLUS;
            n_count       = r_count + 1'b1;
        end else if (w_is_digit) begin
            w_front_valid = 1'b1;
            if (r_count == CNT_W'(STACK_DEPTH)) begin
                w_front_op     = OP_ERR;
                w_front_status = ST_OVERFLOW;
                n_count        = '0;
            end else begin
                w_front_op  = OP_DIGIT;
                w_push      = 1'b1;
                w_push_kind = KIND_DIGIT;
                n_count     = r_count + 1'b1;
            end
        end else if (i_char_code == CH_BS) begin
            w_front_valid = 1'b1;
            if (r_count == '0) begin
                w_front_op     = OP_ERR;
                w_front_status = ST_EMPTY_BS;
            end else begin
                // pop: class comes back from the memory next cycle
                w_front_op = OP_POP;
                w_pop      = 1'b1;
                n_count    = w_count_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // class stack: one write or one read per accepted transaction, so a
    // push and a pop of the same entry always fall on different edges
    always_ff @(posedge i_clk) begin
        if (w_accept && w_push) begin
            r_stack[w_wr_addr] <= w_push_kind;
        end
        if (w_accept && w_pop) begin
            r_kind <= r_stack[w_rd_addr];
        end
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_front_valid;
        end else if (w_s1_retire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op     <= w_front_op;
            r_s1_status <= w_front_status;
            r_s1_digit  <= DIGIT_W'(i_char_code - CH_ZERO);
            r_s1_count  <= r_count;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 control
    // ------------------------------------------------------------------
    always_comb begin
        w_s1_retire = 1'b0;
        w_emit      = 1'b0;
        w_div_start = 1'b0;
        if (r_s1_valid) begin
            case (r_s1_op)
                OP_DIGIT, OP_MINUS, OP_PLUS: w_s1_retire = 1'b1;
                OP_POP: begin
                    case (r_kind)
                        KIND_DIGIT: begin
                            // removed digit: wait for the div10 result
                            w_div_start = !w_div.busy;
                            w_s1_retire = w_div.done;
                        end
                        default: w_s1_retire = 1'b1;
                    endcase
                end
                OP_TERM, OP_ERR: begin
                    w_emit      = w_out_free;
                    w_s1_retire = w_out_free;
                end
                default: w_s1_retire = 1'b1;
            endcase
        end
    end

    decparse_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_value (r_acc),
        .o_stat  (w_div),
        .o_quot  (w_div_quot)
    );

    // acc * 10 + digit, wrapping
    assign w_acc_x10   = (r_acc << 3) + (r_acc << 1) + NUM_W'(r_s1_digit);
    // reported count takes one more for a negative value, wraps to six bits
    assign w_count_sum = {1'b0, r_s1_count} + (CNT_W + 1)'(r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_neg <= 1'b0;
        end else if (r_s1_valid && w_s1_retire) begin
            case (r_s1_op)
                OP_DIGIT: r_acc <= w_acc_x10;
                OP_MINUS: r_neg <= 1'b1;
                OP_PLUS:  r_neg <= 1'b0;
                OP_POP: begin
                    case (r_kind)
                        KIND_DIGIT: r_acc <= w_div_quot;
                        KIND_MINUS: r_neg <= 1'b0;
                        default: begin
                        end
                    endcase
                end
                OP_TERM, OP_ERR: begin
                    // entry done: start fresh
                    r_acc <= '0;
                    r_neg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_s1_op == OP_TERM) begin
                r_out_number <= $signed(r_neg ? -r_acc : r_acc);
                r_out_count  <= CHAR_COUNT_W'(w_count_sum);
                r_out_status <= ST_OK;
            end else begin
                r_out_number <= '0;
                r_out_count  <= '0;
                r_out_status <= r_s1_status;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_number     = r_out_number;
    assign o_char_count = r_out_count;
    assign o_status     = r_out_status;

`ifndef SYNTH
    // kept count never passes the stack depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("kept count beyond stack depth");

    // div10 only runs for a pending pop of a digit
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_s1_valid && (r_s1_op == OP_POP) && (r_kind == KIND_DIGIT)))
        else $error("div10 busy without a digit pop");

    // input held while the divider works, except on its last cycle
    a_div_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div.busy && !w_div.done) |-> o_in_stall)
        else $error("input taken during div10");

    // a finished divide retires the pop and the divider goes idle
    a_div_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |=> !w_div.busy)
        else $error("div10 did not return to idle");
`endif

endmodule

// ===== rtl/decparse_div10.sv =====
// multi-cycle signed divide by ten, truncating toward zero
module decparse_div10 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [decparse_pkg::NUM_W-1:0]  i_value,
    output decparse_pkg::t_div_status       o_stat,
    output logic [decparse_pkg::NUM_W-1:0]  o_quot
);
    import decparse_pkg::*;

    typedef enum logic [6:0] {
        D_IDLE = 7'b0000001,
        D_ABS  = 7'b0000010,
        D_EST  = 7'b0000100,
        D_FOLD = 7'b0001000,
        D_REM  = 7'b0010000,
        D_FIX  = 7'b0100000,
        D_SIGN = 7'b1000000
    } t_dstate;

    t_dstate            r_state, n_state;
    logic               r_neg;
    logic [NUM_W-1:0]   r_n;
    logic [NUM_W-1:0]   r_q;
    logic [4:0]         r_rem;
    logic [FOLD_W-1:0]  r_k;

    logic [NUM_W-1:0]   w_q8;
    logic [4:0]         w_q5;
    logic [4:0]         w_rem;
    logic [5:0]         w_shift;

    // quotient estimate after the fold, and the low bits of n - 10q
    assign w_q8    = r_q >> 3;
    assign w_q5    = w_q8[4:0];
    assign w_rem   = r_n[4:0] - {w_q5[1:0], 3'b000} - {w_q5[3:0], 1'b0};
    assign w_shift = 6'd4 << r_k;

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: if (i_start) n_state = D_ABS;
            D_ABS:  n_state = D_EST;
            D_EST:  n_state = D_FOLD;
            D_FOLD: if (r_k == FOLD_W'(FOLD_STEPS - 1)) n_state = D_REM;
            D_REM:  n_state = D_FIX;
            D_FIX:  n_state = D_SIGN;
            D_SIGN: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                r_neg <= i_value[NUM_W-1];
                r_n   <= i_value;
            end
            D_ABS: begin
                if (r_neg) begin
                    r_n <= -r_n;
                end
            end
            D_EST: begin
                r_q <= (r_n >> 1) + (r_n >> 2);
                r_k <= '0;
            end
            D_FOLD: begin
                r_q <= r_q + (r_q >> w_shift);
                r_k <= r_k + 1'b1;
            end
            D_REM: begin
                r_q   <= w_q8;
                r_rem <= w_rem;
            end
            D_FIX: begin
                r_q <= r_q + NUM_W'(r_rem > 5'd9);
            end
            default: begin
            end
        endcase
    end

    assign o_quot      = r_neg ? -r_q : r_q;
    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.done = (r_state == D_SIGN);

endmodule

// ===== bench/decimal_entry_parser_with_backspace_tb.sv =====
// self-checking bench for the decimal entry parser: random characters against an in-bench predictor
`timescale 1ns / 1ps

module decimal_entry_parser_with_backspace_tb;
    import decparse_pkg::*;

    // expected result of one entry
    typedef struct packed {
        logic [NUM_W-1:0]        number;
        logic [CHAR_COUNT_W-1:0] char_count;
        t_status                 status;
    } t_entry_result;

    localparam logic [NUM_W-1:0] TEN = 64'd10;
    localparam int ITEM_TARGET     = 1650;
    localparam int HOLD_AT         = 400;   // accepted transactions before the long hold-off
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_TAIL      = 200;   // last transactions sent without idling
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 20;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CHAR_W-1:0]        i_char_code = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [NUM_W-1:0]  o_number;
    logic [CHAR_COUNT_W-1:0]  o_char_count;
    logic [STATUS_W-1:0]      o_status;

    decimal_entry_parser_with_backspace dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_number     (o_number),
        .o_char_count (o_char_count),
        .o_status     (o_status)
    );

    // characters waiting to be sent, and entry results waiting to come out
    logic [CHAR_W-1:0] pending_chars [$];
    t_entry_result     entry_results [$];

    // predictor state: one entry in progress
    logic [NUM_W-1:0] acc;
    bit               neg;
    int               kept_len;
    t_kind            kept_kinds [STACK_DEPTH];

    int  n_items;         // characters queued in total
    int  n_accepted;
    int  n_mismatch;
    bit  in_taken;        // a transaction went in at the last rising edge
    int  send_gap;
    int  stall_gap;
    int  hold_left;
    bit  hold_done;
    wire quiet = (n_accepted + QUIET_TAIL >= n_items);
    wire calm  = ((n_accepted / 150) % 4 == 1);   // stretches without any idling

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_terminator(input logic [CHAR_W-1:0] c);
        return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_ESC;
    endfunction

    // apply one accepted character to the entry, queue a result if it ends the entry
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        t_entry_result    res;
        logic [NUM_W-1:0] mag;
        bit               done;
        res  = '0;
        done = 1'b0;
        if (is_terminator(c)) begin
            res.number     = neg ? -acc : acc;
            res.char_count = CHAR_COUNT_W'(kept_len + int'(neg));
            res.status     = ST_OK;
            done           = 1'b1;
        end else if ((c == CH_PLUS || c == CH_MINUS) && kept_len == 0) begin
            // sign counts only as the first kept character
            kept_kinds[0] = (c == CH_MINUS) ? KIND_MINUS : KIND_PLUS;
            kept_len      = 1;
            neg           = (c == CH_MINUS);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (kept_len == STACK_DEPTH) begin
                res.status = ST_OVERFLOW;
                done       = 1'b1;
            end else begin
                kept_kinds[kept_len] = KIND_DIGIT;
                kept_len             = kept_len + 1;
                acc                  = acc * TEN + NUM_W'(c - CH_ZERO);
            end
        end else if (c == CH_BS) begin
            if (kept_len == 0) begin
                res.status = ST_EMPTY_BS;
                done       = 1'b1;
            end else begin
                kept_len = kept_len - 1;
                case (kept_kinds[kept_len])
                    KIND_DIGIT: begin
                        // signed divide, truncating toward zero
                        if (acc[NUM_W-1]) begin
                            mag = -acc;
                            acc = -(mag / TEN);
                        end else begin
                            acc = acc / TEN;
                        end
                    end
                    KIND_MINUS: neg = 1'b0;
                    default: ;
                endcase
            end
        end
        if (done) begin
            entry_results.push_back(res);
            acc      = '0;
            neg      = 1'b0;
            kept_len = 0;
        end
    endfunction

    task automatic queue_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
    endtask

    function automatic logic [CHAR_W-1:0] random_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] random_terminator();
        case ($urandom_range(0, 3))
            0:       return CH_NUL;
            1:       return CH_LF;
            2:       return CH_CR;
            default: return CH_ESC;
        endcase
    endfunction

    // one random entry: mostly well formed, some pure noise, some left unterminated
    task automatic queue_entry();
        int pick;
        int n_digits;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            case ($urandom_range(0, 2))
                1:       queue_char(CH_PLUS);
                2:       queue_char(CH_MINUS);
                default: ;
            endcase
            // long runs wrap the accumulator and overrun the stack
            n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 34)
                                                   : $urandom_range(0, 10);
            for (int i = 0; i < n_digits; i++) begin
                queue_char(random_digit());
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, 2);
                    repeat (n) queue_char(CH_BS);
                end
                if ($urandom_range(0, 11) == 0)
                    queue_char(CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 14) == 0)
                    queue_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end
            // sometimes erase the whole entry, sign included, and maybe beyond
            if ($urandom_range(0, 9) == 0) begin
                n = n_digits + $urandom_range(1, 2);
                repeat (n) queue_char(CH_BS);
            end
            queue_char(random_terminator());
        end else if (pick < 85) begin
            n = $urandom_range(1, 6);
            repeat (n) queue_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       queue_char(CH_PLUS);
                    1:       queue_char(CH_MINUS);
                    2:       queue_char(CH_BS);
                    default: queue_char(random_digit());
                endcase
            end
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        acc        = '0;
        neg        = 1'b0;
        kept_len   = 0;
        n_accepted = 0;
        n_mismatch = 0;
        // directed: empty backspace, signs, ignored late signs, undo of each kind
        queue_char(CH_BS);
        queue_char(CH_MINUS);
        queue_char(CH_ZERO + 8'd5);
        queue_char(CH_PLUS);
        queue_char(CH_MINUS);
        queue_char(CH_BS);
        queue_char(CH_ZERO + 8'd7);
        queue_char(8'hFF);
        queue_char(CH_LF);
        queue_char(CH_PLUS);
        queue_char(CH_BS);
        queue_char(CH_NINE);
        queue_char(CH_CR);
        queue_char(CH_MINUS);
        queue_char(CH_BS);
        queue_char(CH_ZERO);
        queue_char(CH_ESC);
        queue_char(CH_ZERO + 8'd1);
        queue_char(CH_ZERO + 8'd2);
        queue_char(CH_BS);
        queue_char(CH_NUL);
        queue_char(CH_NUL);
        // random entries
        while (pending_chars.size() < ITEM_TARGET)
            queue_entry();
        n_items = pending_chars.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items)
            @(posedge i_clk);
        while (entry_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && entry_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // sender: one character per transaction, held while stalled, idles in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
                send_gap   <= $urandom_range(0, 18);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid  <= 1'b1;
                i_char_code <= pending_chars.pop_front();
            end
        end
    end

    // long receiver hold-off once, so the block backs up and stalls its input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: stalls in random bursts, or for the whole hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap   <= stall_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
            stall_gap   <= $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin
        t_entry_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                parse_char(i_char_code);
                n_accepted <= n_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (entry_results.size() == 0) begin
                    // result with nothing pending
                    if (n_mismatch < MAX_REPORTS)
                        $display("unexpected result: number %0d count %0d status %0d",
                                 o_number, o_char_count, o_status);
                    n_mismatch++;
                end else begin
                    want = entry_results.pop_front();
                    if (o_number !== want.number || o_char_count !== want.char_count
                            || o_status !== want.status) begin
                        if (n_mismatch < MAX_REPORTS)
                            $display("mismatch: number %0d/%0d count %0d/%0d status %0d/%0d",
                                     $signed(want.number), o_number,
                                     want.char_count, o_char_count,
                                     want.status, o_status);
                        n_mismatch++;
                    end
                end
            end
        end
    end

endmodule
